// ===== design/gbr_pkg.sv =====
// Shared types and constants for the 3x3 RGB blur unit.
`default_nettype none

package gbr_pkg;

   // Elaboration defaults for the size parameters of the top level.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Configuration port layout.
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 13;
   localparam int RST_FRAME_WIDTH  = 640;
   localparam int RST_FRAME_HEIGHT = 480;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Channel and kernel arithmetic.
   localparam int PIX_W     = 8;
   localparam int SUM_W     = 12;   // 16 * 255 = 4080
   localparam int SUM_SHIFT = 4;

   typedef logic [PIX_W-1:0] chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   // One column of the window: top, middle, bottom row.
   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } col3_type;

   typedef struct packed {
      col3_type left;
      col3_type mid;
      col3_type right;
   } win_type;

   // One channel of one window column, [2] top .. [0] bottom.
   typedef logic [2:0][PIX_W-1:0] chan3_type;

   // Line memory word: row two back and row one back of the same column.
   typedef struct packed {
      pixel_type far_pix;
      pixel_type near_pix;
   } line_word_type;

   // Per-word flags handed to the output stage.
   typedef struct packed {
      logic keep;
      logic done;
   } flag_type;

endpackage : gbr_pkg

`default_nettype wire

// ===== design/gbr_line_buf.sv =====
// Line memory (two previous rows per column) and the 3x3 window registers.
`default_nettype none

module gbr_line_buf #(
   parameter int MAX_WIDTH = gbr_pkg::DEF_MAX_WIDTH
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         acc,
   input  wire [$clog2(MAX_WIDTH)-1:0] acc_col,
   input  gbr_pkg::pixel_type          acc_pix,
   input  wire                         adv,
   output gbr_pkg::win_type            win
);
   import gbr_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   line_word_type line_mem_ff [MAX_WIDTH];
   line_word_type rd_ff;
   pixel_type     cur_ff;
   logic [AW-1:0] wa_ff;
   col3_type      left_ff, left_in;
   col3_type      mid_ff, mid_in;
   col3_type      right_col;
   line_word_type wb_word;

   // read at accept, data lands with the word in stage 1
   always_ff @(posedge clock) begin
      if (acc) begin
         rd_ff  <= line_mem_ff[acc_col];
         cur_ff <= acc_pix;
         wa_ff  <= acc_col;
      end
   end

   // rows move down one: near becomes far, current becomes near
   assign wb_word = '{far_pix: rd_ff.near_pix, near_pix: cur_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         line_mem_ff[wa_ff] <= wb_word;
      end
   end

   assign right_col = '{top: rd_ff.far_pix, mid: rd_ff.near_pix, bot: cur_ff};

   always_comb begin
      left_in = left_ff;
      mid_in  = mid_ff;
      if (adv) begin
         left_in = mid_ff;
         mid_in  = right_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         mid_ff  <= '0;
      end else begin
         left_ff <= left_in;
         mid_ff  <= mid_in;
      end
   end

   assign win = '{left: left_ff, mid: mid_ff, right: right_col};

endmodule : gbr_line_buf

`default_nettype wire

// ===== design/gbr_lane.sv =====
// One channel lane: binomial 3x3 weighted sum, registered, shifted right by four.
`default_nettype none

module gbr_lane (
   input  wire                 clock,
   input  wire                 en,
   input  gbr_pkg::chan3_type  col_left,
   input  gbr_pkg::chan3_type  col_mid,
   input  gbr_pkg::chan3_type  col_right,
   output gbr_pkg::chan_type   result
);
   import gbr_pkg::*;

   logic [SUM_W-1:0] sum;
   chan_type         result_ff;

   // weights 1 2 1 / 2 4 2 / 1 2 1
   always_comb begin
      sum = SUM_W'(col_left[2])  + SUM_W'({col_mid[2], 1'b0})  + SUM_W'(col_right[2])
          + SUM_W'({col_left[1], 1'b0}) + SUM_W'({col_mid[1], 2'b00})
          + SUM_W'({col_right[1], 1'b0})
          + SUM_W'(col_left[0])  + SUM_W'({col_mid[0], 1'b0})  + SUM_W'(col_right[0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= sum[SUM_W-1:SUM_SHIFT];
      end
   end

   assign result = result_ff;

endmodule : gbr_lane

`default_nettype wire

// ===== design/gbr_merge.sv =====
// Merge of the three lane results with position tags into the output register and skid.
`default_nettype none

module gbr_merge #(
   parameter int COL_W = 10,
   parameter int ROW_W = 12
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                load,
   input  gbr_pkg::chan_type  lane_red,
   input  gbr_pkg::chan_type  lane_green,
   input  gbr_pkg::chan_type  lane_blue,
   input  wire [COL_W-1:0]    tag_col,
   input  wire [ROW_W-1:0]    tag_row,
   input  gbr_pkg::flag_type  tag_flag,
   output logic               skid_full,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output gbr_pkg::chan_type  rsp_blur_red,
   output gbr_pkg::chan_type  rsp_blur_green,
   output gbr_pkg::chan_type  rsp_blur_blue,
   output logic [COL_W-1:0]   rsp_out_col,
   output logic [ROW_W-1:0]   rsp_out_row,
   output logic               rsp_frame_done
);
   import gbr_pkg::*;

   typedef struct packed {
      chan_type         red;
      chan_type         green;
      chan_type         blue;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             done;
   } rsp_word_type;

   rsp_word_type new_word;
   rsp_word_type out_ff, out_in;
   rsp_word_type skid_ff, skid_in;
   logic         out_v_ff, out_v_in;
   logic         skid_v_ff, skid_v_in;

   assign new_word = '{red: lane_red, green: lane_green, blue: lane_blue,
                       col: tag_col, row: tag_row, done: tag_flag.done};

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (!rsp_stall) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (load) begin
         if (out_v_ff && rsp_stall) begin
            skid_in   = new_word;
            skid_v_in = 1'b1;
         end else begin
            out_in   = new_word;
            out_v_in = 1'b1;
         end
      end else if (!rsp_stall) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign skid_full      = skid_v_ff;
   assign rsp_valid      = out_v_ff;
   assign rsp_blur_red   = out_ff.red;
   assign rsp_blur_green = out_ff.green;
   assign rsp_blur_blue  = out_ff.blue;
   assign rsp_out_col    = out_ff.col;
   assign rsp_out_row    = out_ff.row;
   assign rsp_frame_done = out_ff.done;

endmodule : gbr_merge

`default_nettype wire

// ===== design/gaussian_blur_3x3_rgb_unit.sv =====
// Top level of the streaming 3x3 binomial blur for RGB rasters.
`default_nettype none

// Streaming 3x3 Gaussian (binomial 1 2 1) blur over an RGB raster. Pixels
// enter in raster order, one word per clock, and the unit sustains one word
// per clock in both directions while the output skid is not full; a blurred
// word is held in stage 1, the lane result register and then the output
// register after the pixel that completes its window (the pixel below and
// right of it) is taken. Only interior positions produce a word: the first
// and last row and column of a frame produce none, so a W x H frame yields
// (W-2)*(H-2) words, the last one flagged with rsp_frame_done. Each channel
// runs through its own lane; the sum is truncated (>> 4). The rate is set by
// the line memory, which is read for a column as the pixel is taken and
// written back as the word leaves stage 1, and by the output stage, which
// holds one word plus one skid word so that a stall on the output side
// reaches the input only when both are full. Size registers (index 0 width,
// index 1 height) are saturated to 3..MAX_WIDTH and 3..MAX_HEIGHT, and any
// write to them restarts the frame at row 0, column 0; write them only while
// the unit is idle. The line memory is not cleared: it needs no clearing
// pass after reset because the first two rows of each frame, which read it
// before writing it, never produce a word.
module gaussian_blur_3x3_rgb_unit #(
   parameter int MAX_WIDTH  = gbr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gbr_pkg::DEF_MAX_HEIGHT
) (
   input  wire                              clock,
   input  wire                              reset,
   // pixel input
   input  wire                              req_valid,
   output logic                             req_stall,
   input  gbr_pkg::chan_type                req_pix_red,
   input  gbr_pkg::chan_type                req_pix_green,
   input  gbr_pkg::chan_type                req_pix_blue,
   // blurred output
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output gbr_pkg::chan_type                rsp_blur_red,
   output gbr_pkg::chan_type                rsp_blur_green,
   output gbr_pkg::chan_type                rsp_blur_blue,
   output logic [$clog2(MAX_WIDTH)-1:0]     rsp_out_col,
   output logic [$clog2(MAX_HEIGHT)-1:0]    rsp_out_row,
   output logic                             rsp_frame_done,
   // register writes
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [gbr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [gbr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gbr_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   // last valid index of a saturated size (size 3..max_size)
   function automatic int sat_last(input int raw, input int max_size);
      return (raw < 3) ? 2 : ((raw > max_size) ? (max_size - 1) : (raw - 1));
   endfunction

   function automatic chan3_type pick_chan(input col3_type c, input int ch);
      chan3_type r;
      case (ch)
         0:       r = {c.top.red,   c.mid.red,   c.bot.red};
         1:       r = {c.top.green, c.mid.green, c.bot.green};
         default: r = {c.top.blue,  c.mid.blue,  c.bot.blue};
      endcase
      return r;
   endfunction

   logic             en;
   logic             acc;
   logic             csr_wr;
   logic             skid_full;
   pixel_type        acc_pix;
   win_type          win;
   chan_type         lane_res [3];

   // frame position of the next pixel and saturated frame size
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;

   // tags riding along stage 1 (memory read done) and stage 2 (lane sums)
   logic             s1_v_ff, s1_v_in;
   logic             s2_v_ff, s2_v_in;
   logic [COL_W-1:0] s1_col_ff, s2_col_ff;
   logic [ROW_W-1:0] s1_row_ff, s2_row_ff;
   flag_type         s1_flag_ff, s2_flag_ff;
   flag_type         s0_flag;

   // whole pipe moves unless the output skid is holding a word
   assign en        = !skid_full;
   assign req_stall = !en;
   assign acc       = req_valid && en;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   assign acc_pix = '{red: req_pix_red, green: req_pix_green, blue: req_pix_blue};

   // position counters and size registers
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_last_in = COL_W'(sat_last(int'(csr_wdata[FRAME_WIDTH_W-1:0]), MAX_WIDTH));
               col_in    = '0;
               row_in    = '0;
            end
            CSR_FRAME_HEIGHT: begin
               h_last_in = ROW_W'(sat_last(int'(csr_wdata[FRAME_HEIGHT_W-1:0]), MAX_HEIGHT));
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (acc) begin
         if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = (row_ff == h_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         w_last_ff <= COL_W'(sat_last(RST_FRAME_WIDTH, MAX_WIDTH));
         h_last_ff <= ROW_W'(sat_last(RST_FRAME_HEIGHT, MAX_HEIGHT));
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
      end
   end

   // interior test and frame-end flag, worked out as the pixel is taken
   assign s0_flag.keep = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign s0_flag.done = (row_ff == h_last_ff) && (col_ff == w_last_ff);

   assign s1_v_in = en ? acc     : s1_v_ff;
   assign s2_v_in = en ? s1_v_ff : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_col_ff  <= col_ff - COL_W'(1);
         s1_row_ff  <= row_ff - ROW_W'(1);
         s1_flag_ff <= s0_flag;
      end
      if (en) begin
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_flag_ff <= s1_flag_ff;
      end
   end

   gbr_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .acc     (acc),
      .acc_col (col_ff),
      .acc_pix (acc_pix),
      .adv     (en && s1_v_ff),
      .win     (win)
   );

   // one lane per channel: 0 red, 1 green, 2 blue
   for (genvar ch = 0; ch < 3; ch++) begin : g_lane
      gbr_lane u_lane (
         .clock     (clock),
         .en        (en && s1_v_ff),
         .col_left  (pick_chan(win.left, ch)),
         .col_mid   (pick_chan(win.mid, ch)),
         .col_right (pick_chan(win.right, ch)),
         .result    (lane_res[ch])
      );
   end

   gbr_merge #(
      .COL_W (COL_W),
      .ROW_W (ROW_W)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (en && s2_v_ff && s2_flag_ff.keep),
      .lane_red       (lane_res[0]),
      .lane_green     (lane_res[1]),
      .lane_blue      (lane_res[2]),
      .tag_col        (s2_col_ff),
      .tag_row        (s2_row_ff),
      .tag_flag       (s2_flag_ff),
      .skid_full      (skid_full),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blur_red   (rsp_blur_red),
      .rsp_blur_green (rsp_blur_green),
      .rsp_blur_blue  (rsp_blur_blue),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done)
   );

`ifndef ASSERT_OFF
   // skid only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid word present without output word");

   // column counter stays within the configured row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last_ff)
      else $error("column counter past frame width");

   // frame-end word sits on the last interior column
   a_done_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_out_col == w_last_ff - COL_W'(1)))
      else $error("frame done on wrong column");

   // an interior word never carries column 0 or row 0
   a_interior_pos: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_flag_ff.keep) |-> (s2_col_ff != '0 && s2_row_ff != '0))
      else $error("interior word tagged with border position");
`endif

endmodule : gaussian_blur_3x3_rgb_unit

`default_nettype wire

// ===== tb/sv/tb_gaussian_blur_3x3_rgb_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 RGB blur unit, with a scoreboard on its output.

module tb_gaussian_blur_3x3_rgb_unit;
   import gbr_pkg::*;

   localparam int MAX_W = DEF_MAX_WIDTH;
   localparam int MAX_H = DEF_MAX_HEIGHT;
   localparam int COL_W = $clog2(MAX_W);
   localparam int ROW_W = $clog2(MAX_H);

   localparam int PERIOD        = 20;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 8;         // lets the pipe drain after the queues empty
   localparam int HOLD_CYCLES   = 400;       // long output-side hold, fills the unit
   localparam int RANDOM_ITEMS  = 1200;
   localparam int WIDE_W        = 160;       // row width of the held frame
   localparam int TALL_ITEMS    = 30;        // first rows of the saturated-height frame
   localparam int MAX_REPORTS   = 10;
   localparam int LIMIT_CYCLES  = 2_000_000;

   // Indexes past the register list: the unit must ignore them.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // One blurred output word as the scoreboard holds it.
   typedef struct packed {
      pixel_type          pix;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic               done;
   } blur_word_type;

   // Output-side stall patterns; each runs for a random span of cycles.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // ---------------------------------------------------------------------
   // DUT ports
   // ---------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   chan_type                req_pix_red = '0;
   chan_type                req_pix_green = '0;
   chan_type                req_pix_blue = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   chan_type                rsp_blur_red;
   chan_type                rsp_blur_green;
   chan_type                rsp_blur_blue;
   logic [COL_W-1:0]        rsp_out_col;
   logic [ROW_W-1:0]        rsp_out_row;
   logic                    rsp_frame_done;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   gaussian_blur_3x3_rgb_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pix_red    (req_pix_red),
      .req_pix_green  (req_pix_green),
      .req_pix_blue   (req_pix_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blur_red   (rsp_blur_red),
      .rsp_blur_green (rsp_blur_green),
      .rsp_blur_blue  (rsp_blur_blue),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Testbench state
   // ---------------------------------------------------------------------
   pixel_type     pixels_to_send [$];   // filled by the stimulus, drained by the driver
   blur_word_type blurs_due [$];        // blurred words predicted but not yet seen
   int unsigned   pix_accepted = 0;
   int unsigned   fail_count = 0;
   bit            pix_taken = 1'b0;     // set on the edge that accepts the held word

   // sender pacing
   int unsigned   burst_left = 1;
   int unsigned   gap_left = 0;

   // receiver pacing
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned   stall_span = 0;
   logic          rsp_hold = 1'b0;      // long hold, driven by its own process
   int unsigned   hold_from = 0;
   int unsigned   holds_asked = 0;

   // Shadow of the unit: size registers, frame position, line stores, window.
   logic [FRAME_WIDTH_W-1:0]  width_reg = FRAME_WIDTH_W'(RST_FRAME_WIDTH);
   logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_W'(RST_FRAME_HEIGHT);
   int unsigned               img_col = 0;
   int unsigned               img_row = 0;
   pixel_type                 line_near [MAX_W];
   pixel_type                 line_far [MAX_W];
   col3_type                  win_left = '0;
   col3_type                  win_mid = '0;

   // ---------------------------------------------------------------------
   // Blur predictor
   // ---------------------------------------------------------------------
   // Size registers saturate to 3..max.
   function automatic int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg < 3) return 3;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
   endfunction

   // One channel of a window column, top in [2], bottom in [0].
   function automatic chan3_type column_lane(col3_type c, int unsigned sh);
      return {c.top[sh +: PIX_W], c.mid[sh +: PIX_W], c.bot[sh +: PIX_W]};
   endfunction

   // Advance the shadow by one pixel; queue a blurred word when the pixel
   // completes the window of an interior position (the one up and left).
   function automatic void blur_step(pixel_type px);
      int unsigned   wd;
      int unsigned   ht;
      int unsigned   acc;
      col3_type      right;
      chan3_type     l;
      chan3_type     m;
      chan3_type     r;
      blur_word_type word;
      wd = eff_width();
      ht = eff_height();
      right.top = line_far[img_col];
      right.mid = line_near[img_col];
      right.bot = px;
      line_far[img_col]  = right.mid;
      line_near[img_col] = px;
      if (img_row >= 2 && img_col >= 2) begin
         for (int sh = 0; sh < 3 * PIX_W; sh += PIX_W) begin
            l = column_lane(win_left, sh);
            m = column_lane(win_mid, sh);
            r = column_lane(right, sh);
            // 1 2 1 / 2 4 2 / 1 2 1, truncated by the shift
            acc = l[2] + 2 * m[2] + r[2]
                + 2 * (l[1] + 2 * m[1] + r[1])
                + l[0] + 2 * m[0] + r[0];
            word.pix[sh +: PIX_W] = chan_type'(acc >> SUM_SHIFT);
         end
         word.col  = COL_W'(img_col - 1);
         word.row  = ROW_W'(img_row - 1);
         word.done = (img_row + 1 == ht) && (img_col + 1 == wd);
         blurs_due.push_back(word);
      end
      win_left = win_mid;
      win_mid  = right;
      img_col++;
      if (img_col >= wd) begin
         img_col = 0;
         img_row = (img_row + 1 >= ht) ? 0 : img_row + 1;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Pixel driver: changes at the falling edge, bursts with random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         blur_step({req_pix_red, req_pix_green, req_pix_blue});
         void'(pixels_to_send.pop_front());
         pix_taken = 1'b1;
         pix_accepted++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pix_taken) begin
         // a held word stays put until taken; otherwise pick the next move
         pix_taken = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixels_to_send.size() != 0) begin
            req_valid <= 1'b1;
            {req_pix_red, req_pix_green, req_pix_blue} <= pixels_to_send[0];
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               // a third of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall pattern of its own, plus the long hold
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : receiver_pace
      logic want_stall;
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(16, 160);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE:     want_stall = 1'b0;
         STALL_LIGHT:    want_stall = ($urandom_range(0, 4) == 0);
         STALL_PERIODIC: want_stall = (stall_span[1:0] == 2'd0);
         STALL_HEAVY:    want_stall = ($urandom_range(0, 3) != 0);
         default:        want_stall = 1'b0;
      endcase
      rsp_stall <= !reset && (want_stall || rsp_hold);
   end

   // Long hold: once asked, waits for the pixel count, then stalls the
   // output while the sender keeps offering.
   initial begin : receiver_hold
      int unsigned holds_done;
      holds_done = 0;
      forever begin
         while (holds_done == holds_asked || pix_accepted < hold_from)
            @(negedge clock);
         holds_done++;
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Output checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : blur_check
      blur_word_type want;
      blur_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_blur_red, rsp_blur_green, rsp_blur_blue,
                rsp_out_col, rsp_out_row, rsp_frame_done};
         if (blurs_due.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected blurred word rgb %h col %0d row %0d done %b",
                        $time, got.pix, got.col, got.row, got.done);
         end else begin
            want = blurs_due.pop_front();
            if (got.pix !== want.pix || got.col !== want.col ||
                got.row !== want.row || got.done !== want.done) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: blur mismatch: exp rgb %h col %0d row %0d done %b, ",
                           $time, want.pix, want.col, want.row, want.done,
                           "got rgb %h col %0d row %0d done %b",
                           got.pix, got.col, got.row, got.done);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   // Mostly random channel values, with the rails mixed in.
   function automatic chan_type rand_chan();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return chan_type'($urandom);
      endcase
   endfunction

   function automatic void queue_random_pixels(int unsigned n);
      repeat (n) pixels_to_send.push_back({rand_chan(), rand_chan(), rand_chan()});
   endfunction

   // Idle means: nothing left to send, nothing expected, pipe flushed
   // (words that make no blurred output may still be in flight).
   task automatic wait_idle();
      while (pixels_to_send.size() != 0 || blurs_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; the shadow follows the write as soon as it lands.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_WIDTH: begin
            width_reg = data[FRAME_WIDTH_W-1:0];
            img_col = 0;
            img_row = 0;
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = data[FRAME_HEIGHT_W-1:0];
            img_col = 0;
            img_row = 0;
         end
         default: ;   // spare index: no effect, frame carries on
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned   random_items;
      int unsigned   per_frame;
      int unsigned   n;
      int unsigned   half;
      int unsigned   pick;
      logic [10:0]   size_w;
      logic [12:0]   size_h;
      pixel_type     px;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: 3x3 frames, each gives one word flagged frame_done ---
      // width 0 and height 2 are below range and act as 3
      csr_write(CSR_FRAME_WIDTH, 13'd0);
      csr_write(CSR_FRAME_HEIGHT, 13'd2);

      // full-scale frame: sum 4080 on every channel
      repeat (9) pixels_to_send.push_back('1);

      // truncation: red sums to 4, green to exactly 16, blue to 15
      for (int i = 0; i < 9; i++) begin
         px.red   = (i == 4) ? 8'd1 : 8'd0;
         px.green = 8'd1;
         px.blue  = (i == 4) ? 8'd3 : (i == 0 || i == 2 || i == 6) ? 8'd1 : 8'd0;
         pixels_to_send.push_back(px);
      end

      // spare indexes mid-frame: the frame must not restart; the sender
      // also sits idle here until the pipe is empty
      queue_random_pixels(4);
      wait_idle();
      csr_write(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      csr_write(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      queue_random_pixels(5);
      wait_idle();

      // --- random phases on small frames ---
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            size_w = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 2))
                                                 : 11'($urandom_range(3, 12));
            size_h = ($urandom_range(0, 5) == 0) ? 13'($urandom_range(0, 2))
                                                 : 13'($urandom_range(3, 8));
            // top two data bits lie past the width register and are dropped
            if ($urandom_range(0, 3) != 0)
               csr_write(CSR_FRAME_WIDTH, {2'($urandom), size_w});
            if ($urandom_range(0, 3) != 0)
               csr_write(CSR_FRAME_HEIGHT, size_h);
         end else if (pick == 8) begin
            csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      CSR_DATA_W'($urandom));
         end
         // one or two frames and a partial one; the frame may already be
         // partway through when no size was written
         per_frame = eff_width() * eff_height();
         n = per_frame * $urandom_range(1, 2) + $urandom_range(0, per_frame - 1);
         if ($urandom_range(0, 3) == 0) begin
            half = n / 2;
            queue_random_pixels(half);
            wait_idle();
            queue_random_pixels(n - half);
         end else begin
            queue_random_pixels(n);
         end
         random_items += n;
         wait_idle();
      end

      // --- wider frame, three rows ---
      // the long output hold lands once blurred words are flowing
      csr_write(CSR_FRAME_WIDTH, CSR_DATA_W'(WIDE_W));
      csr_write(CSR_FRAME_HEIGHT, 13'd3);
      hold_from = pix_accepted + 2 * WIDE_W + 20;
      holds_asked++;
      queue_random_pixels(3 * WIDE_W);
      wait_idle();

      // --- 8191 saturates to MAX_H: three columns, first rows only ---
      csr_write(CSR_FRAME_WIDTH, 13'd3);
      csr_write(CSR_FRAME_HEIGHT, '1);
      queue_random_pixels(TALL_ITEMS);
      wait_idle();

      if (fail_count == 0 && blurs_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #(longint'(LIMIT_CYCLES) * PERIOD);
      $display("TEST FAILED");
      $finish;
   end

endmodule
